>>> rtl/bfgd_pkg.sv
`default_nettype none

package bfgd_pkg;

    // Default duty resolution and the resolution the gamma table is built for.
    localparam int DUTY_BITS_DEFAULT = 10;
    localparam int ROM_BITS          = 10;

    // Brightness levels, the percent-to-table mapping and the reset band edges.
    localparam logic [6:0] FULL_PCT       = 7'd100;
    localparam logic [6:0] LEVEL_RESET    = 7'd99;
    localparam logic [6:0] TARGET_RESET   = 7'd100;
    localparam logic [9:0] BAND_LOW_RESET  = 10'd510;
    localparam logic [9:0] BAND_HIGH_RESET = 10'd560;

    // Register indexes on the configuration channel.
    localparam logic [7:0] REG_BAND_LOW  = 8'd0;
    localparam logic [7:0] REG_BAND_HIGH = 8'd1;

    // Item kinds carried in the input tuser.
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [9:0] band_low;
        logic [9:0] band_high;
    } band_cfg_t;

    // Gamma 2.2 table for mapped brightness 30..100, indexed from 0.
    function automatic logic [ROM_BITS-1:0] gamma_lookup(input logic [6:0] idx);
        logic [ROM_BITS-1:0] v;
        case (idx)
            7'd0:  v = 10'd72;   7'd1:  v = 10'd77;   7'd2:  v = 10'd83;
            7'd3:  v = 10'd89;   7'd4:  v = 10'd95;   7'd5:  v = 10'd101;
            7'd6:  v = 10'd108;  7'd7:  v = 10'd114;  7'd8:  v = 10'd121;
            7'd9:  v = 10'd128;  7'd10: v = 10'd136;  7'd11: v = 10'd143;
            7'd12: v = 10'd151;  7'd13: v = 10'd159;  7'd14: v = 10'd168;
            7'd15: v = 10'd176;  7'd16: v = 10'd185;  7'd17: v = 10'd194;
            7'd18: v = 10'd203;  7'd19: v = 10'd212;  7'd20: v = 10'd222;
            7'd21: v = 10'd232;  7'd22: v = 10'd242;  7'd23: v = 10'd253;
            7'd24: v = 10'd263;  7'd25: v = 10'd274;  7'd26: v = 10'd285;
            7'd27: v = 10'd297;  7'd28: v = 10'd308;  7'd29: v = 10'd320;
            7'd30: v = 10'd332;  7'd31: v = 10'd344;  7'd32: v = 10'd357;
            7'd33: v = 10'd370;  7'd34: v = 10'd383;  7'd35: v = 10'd396;
            7'd36: v = 10'd410;  7'd37: v = 10'd423;  7'd38: v = 10'd437;
            7'd39: v = 10'd452;  7'd40: v = 10'd466;  7'd41: v = 10'd481;
            7'd42: v = 10'd496;  7'd43: v = 10'd511;  7'd44: v = 10'd527;
            7'd45: v = 10'd543;  7'd46: v = 10'd559;  7'd47: v = 10'd575;
            7'd48: v = 10'd592;  7'd49: v = 10'd609;  7'd50: v = 10'd626;
            7'd51: v = 10'd643;  7'd52: v = 10'd661;  7'd53: v = 10'd678;
            7'd54: v = 10'd697;  7'd55: v = 10'd715;  7'd56: v = 10'd734;
            7'd57: v = 10'd753;  7'd58: v = 10'd772;  7'd59: v = 10'd791;
            7'd60: v = 10'd811;  7'd61: v = 10'd831;  7'd62: v = 10'd851;
            7'd63: v = 10'd872;  7'd64: v = 10'd892;  7'd65: v = 10'd913;
            7'd66: v = 10'd935;  7'd67: v = 10'd956;  7'd68: v = 10'd978;
            7'd69: v = 10'd1000; 7'd70: v = 10'd1023;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/backlight_fade_gamma_duty.sv
`default_nettype none

// Channel   Direction  Signals                          Word contents
// --------  ---------  -------------------------------  ------------------------------
// s_*       in         s_tvalid s_tready s_tdata s_tuser target_percent; op in tuser
// m_*       out        m_tvalid m_tready m_tdata m_tuser duty, level; duty_updated
// cfg_*     in         cfg_valid cfg_ready cfg_index    band_low (0), band_high (1)
//                      cfg_data
//
// Each word passes through the input register and then the result register.
// One word per cycle is sustained while m_tready is high; the level step,
// duty mapping and state update all happen between the two registers.
// A stall on m_tready holds the result register, then the input register,
// then drops s_tready. Reset restores level 99, target 100, duty 0 and the
// default band edges 510 and 560. Configuration writes are always accepted.
module backlight_fade_gamma_duty
    import bfgd_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] target_percent
    input  wire logic [0:0]  s_tuser,   // [0] op

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [9:0] duty, [16:10] level, rest zero
    output logic      [0:0]  m_tuser,   // [0] duty_updated

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    // Input register.
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [7:0]           in_pct_reg;

    // Block state.
    logic [6:0]           level_reg,  level_next;
    logic [6:0]           target_reg, target_next;
    logic [DUTY_BITS-1:0] held_reg,   held_next;
    band_cfg_t            band_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [9:0]           out_duty_reg;
    logic [6:0]           out_level_reg;
    logic                 out_updated_reg;

    logic                 advance;
    logic                 updated;
    logic [6:0]           step_level;
    logic [DUTY_BITS-1:0] mapped_duty;
    logic [31:0]          held_wide;

    // The head word moves on whenever the result register is empty or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign step_level = (level_reg < target_reg) ? (level_reg + 7'd1) : (level_reg - 7'd1);

    bfgd_duty_map #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty_map (
        .level (step_level),
        .band  (band_reg),
        .duty  (mapped_duty)
    );

    always_comb
    begin
        level_next  = level_reg;
        target_next = target_reg;
        held_next   = held_reg;
        updated     = 1'b0;
        if (advance)
        begin
            if (in_op_reg == OP_SET)
            begin
                target_next = (in_pct_reg > {1'b0, FULL_PCT}) ? FULL_PCT : in_pct_reg[6:0];
            end
            else if (level_reg != target_reg)
            begin
                level_next = step_level;
                held_next  = mapped_duty;
                updated    = 1'b1;
            end
        end
        // The reported duty is the low ten bits of the held value.
        held_wide = 32'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser[0];
            in_pct_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= LEVEL_RESET;
            target_reg <= TARGET_RESET;
            held_reg   <= '0;
        end
        else
        begin
            level_reg  <= level_next;
            target_reg <= target_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg.band_low  <= BAND_LOW_RESET;
            band_reg.band_high <= BAND_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BAND_LOW:  band_reg.band_low  <= cfg_data;
                REG_BAND_HIGH: band_reg.band_high <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_duty_reg    <= held_wide[9:0];
            out_level_reg   <= level_next;
            out_updated_reg <= updated;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_level_reg, out_duty_reg};
    assign m_tuser  = out_updated_reg;

endmodule

`default_nettype wire

>>> rtl/bfgd_duty_map.sv
`default_nettype none

// Maps a brightness level to a gamma-corrected duty and snaps it out of the
// forbidden band.
module bfgd_duty_map
    import bfgd_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEFAULT
)
(
    input  wire logic [6:0]           level,
    input  wire band_cfg_t            band,
    output logic      [DUTY_BITS-1:0] duty
);

    localparam int SHL = (DUTY_BITS >= ROM_BITS) ? (DUTY_BITS - ROM_BITS) : 0;
    localparam int SHR = (DUTY_BITS >= ROM_BITS) ? 0 : (ROM_BITS - DUTY_BITS);

    logic [9:0]           lvl_x7;
    logic [17:0]          recip_prod;
    logic [6:0]           rom_idx;
    logic [ROM_BITS-1:0]  rom_val;
    logic [31:0]          scaled_wide;
    logic [DUTY_BITS-1:0] raw;
    logic [16:0]          raw_ext;
    logic [16:0]          low_ext;
    logic [16:0]          high_ext;
    logic [10:0]          band_sum;
    logic [16:0]          mid_ext;

    always_comb
    begin
        // floor(level*70/100) equals floor(7*level/10); 205/2048 is exact here.
        lvl_x7      = {3'b000, level} * 10'd7;
        recip_prod  = {8'b0, lvl_x7} * 18'd205;
        rom_idx     = recip_prod[17:11];
        rom_val     = gamma_lookup(rom_idx);
        scaled_wide = ({22'b0, rom_val} << SHL) >> SHR;
        raw         = scaled_wide[DUTY_BITS-1:0];

        raw_ext  = 17'(raw);
        low_ext  = {7'b0, band.band_low};
        high_ext = {7'b0, band.band_high};
        band_sum = {1'b0, band.band_low} + {1'b0, band.band_high};
        mid_ext  = {7'b0, band_sum[10:1]};

        if (level == 7'd0)
        begin
            duty = '0;
        end
        else if ((raw_ext > low_ext) && (raw_ext < high_ext))
        begin
            duty = (raw_ext < mid_ext) ? low_ext[DUTY_BITS-1:0] : high_ext[DUTY_BITS-1:0];
        end
        else
        begin
            duty = raw;
        end
    end

endmodule

`default_nettype wire

>>> bench/backlight_fade_gamma_duty_tb.sv
`timescale 1ns / 1ps

module backlight_fade_gamma_duty_tb;
    import bfgd_pkg::*;

    // The mapped brightness is 30 + level*70/100; the table starts at 30, so the
    // table position is simply level*70/100.
    localparam int MAP_SPAN  = 70;
    localparam int MAX_STALL = 4;
    localparam int MAX_LOGGED = 50;

    // Gamma 2.2 curve for mapped brightness 30..100, truncated to 10 bits.
    localparam logic [9:0] GAMMA_TABLE [71] = '{
        10'd72,  10'd77,  10'd83,  10'd89,  10'd95,  10'd101, 10'd108, 10'd114,
        10'd121, 10'd128, 10'd136, 10'd143, 10'd151, 10'd159, 10'd168, 10'd176,
        10'd185, 10'd194, 10'd203, 10'd212, 10'd222, 10'd232, 10'd242, 10'd253,
        10'd263, 10'd274, 10'd285, 10'd297, 10'd308, 10'd320, 10'd332, 10'd344,
        10'd357, 10'd370, 10'd383, 10'd396, 10'd410, 10'd423, 10'd437, 10'd452,
        10'd466, 10'd481, 10'd496, 10'd511, 10'd527, 10'd543, 10'd559, 10'd575,
        10'd592, 10'd609, 10'd626, 10'd643, 10'd661, 10'd678, 10'd697, 10'd715,
        10'd734, 10'd753, 10'd772, 10'd791, 10'd811, 10'd831, 10'd851, 10'd872,
        10'd892, 10'd913, 10'd935, 10'd956, 10'd978, 10'd1000, 10'd1023
    };

    // One input word: the item kind travels in tuser, the percent in tdata.
    typedef struct packed {
        logic       op;
        logic [7:0] pct;
    } fade_word_t;

    // One result word as the block should report it.
    typedef struct packed {
        logic [9:0] duty;
        logic [6:0] level;
        logic       updated;
    } duty_report_t;

    // All block inputs start at known values; reset is held low from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_ready;

    backlight_fade_gamma_duty dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be driven, and the reports the block still owes us.
    fade_word_t   words_to_send[$];
    duty_report_t pending_reports[$];

    // Our own copy of the fade state and of the band registers.
    logic [6:0] lvl_now   = LEVEL_RESET;
    logic [6:0] lvl_goal  = TARGET_RESET;
    logic [9:0] duty_held = '0;
    logic [9:0] band_lo   = BAND_LOW_RESET;
    logic [9:0] band_hi   = BAND_HIGH_RESET;

    // Handshakes seen at the last rising edge, read by the drivers at the
    // following falling edge.
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;

    // When set, neither side inserts gaps or stalls.
    logic steady = 1'b0;
    int   send_gap  = 0;
    int   out_stall = 0;

    int errors       = 0;
    int words_sent   = 0;
    int reports_seen = 0;
    int duty_changes = 0;
    int reg_writes   = 0;
    int band_phases  = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        // Keep the log short when the block is badly broken.
        if (errors <= MAX_LOGGED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advances the fade state by one word and returns what the block must report.
    function automatic duty_report_t predict_fade(input fade_word_t w);
        duty_report_t r;
        int           pos;
        logic [9:0]   raw;
        logic [10:0]  mid;
        r.updated = 1'b0;
        if (w.op == OP_SET)
        begin
            lvl_goal = (w.pct > FULL_PCT) ? FULL_PCT : w.pct[6:0];
        end
        else if (lvl_now != lvl_goal)
        begin
            lvl_now = (lvl_now < lvl_goal) ? lvl_now + 7'd1 : lvl_now - 7'd1;
            if (lvl_now == 7'd0)
            begin
                duty_held = '0;
            end
            else
            begin
                pos = (int'(lvl_now) * MAP_SPAN) / int'(FULL_PCT);
                raw = GAMMA_TABLE[pos];
                // Duties strictly inside the band snap to an edge; the
                // midpoint itself goes to the upper edge.
                mid = ({1'b0, band_lo} + {1'b0, band_hi}) >> 1;
                if (raw > band_lo && raw < band_hi)
                    raw = ({1'b0, raw} < mid) ? band_lo : band_hi;
                duty_held = raw;
            end
            r.updated = 1'b1;
        end
        r.duty  = duty_held;
        r.level = lvl_now;
        return r;
    endfunction

    // Input driver: a word stays on the bus until it is taken, then the next
    // one follows after a random gap, or at once when steady is set.
    always @(negedge clk)
    begin
        fade_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (words_to_send.size() != 0)
            begin
                w = words_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.pct;
                s_tuser  <= w.op;
                send_gap = steady ? 0 : $urandom_range(0, MAX_STALL);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: after each word it takes, it holds off for a random stretch, or not at all when steady is set.
    always @(negedge clk)
    begin
        if (m_fire)
            out_stall = steady ? 0 : $urandom_range(0, MAX_STALL);
        if (out_stall > 0)
        begin
            out_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result word against the oldest prediction, then
    // tracks register writes and predicts for each input word taken.
    always @(posedge clk)
    begin
        duty_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                reports_seen++;
                if (pending_reports.size() == 0)
                begin
                    report_mismatch("result word with nothing outstanding",
                                    int'(m_tdata[16:0]), 0);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (m_tdata[9:0] != want.duty)
                        report_mismatch("duty", int'(m_tdata[9:0]), int'(want.duty));
                    if (m_tdata[16:10] != want.level)
                        report_mismatch("level", int'(m_tdata[16:10]), int'(want.level));
                    if (m_tuser[0] != want.updated)
                        report_mismatch("duty_updated", int'(m_tuser[0]),
                                        int'(want.updated));
                    if (m_tdata[23:17] != '0)
                        report_mismatch("tdata padding", int'(m_tdata[23:17]), 0);
                    if (want.updated)
                        duty_changes++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                // Writes to any other index are expected to be dropped.
                if (cfg_index == REG_BAND_LOW)
                    band_lo = cfg_data;
                else if (cfg_index == REG_BAND_HIGH)
                    band_hi = cfg_data;
                reg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                pending_reports.push_back(predict_fade('{op: s_tuser[0], pct: s_tdata}));
                words_sent++;
            end
        end
        s_fire <= rst_n && s_tvalid && s_tready;
        m_fire <= rst_n && m_tvalid && m_tready;
    end

    task automatic send_word(input logic op, input logic [7:0] pct);
        fade_word_t w;
        w.op  = op;
        w.pct = pct;
        words_to_send.push_back(w);
    endtask

    // Waits until every queued word is taken and every result has come back,
    // then lets the two-stage pipeline settle.
    task automatic wait_idle();
        while (words_to_send.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [9:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sets both band edges while the block is idle, plus one write to an
    // index that does not exist, which must change nothing.
    task automatic set_band(input logic [9:0] lo, input logic [9:0] hi);
        wait_idle();
        write_reg(REG_BAND_LOW, lo);
        write_reg(8'($urandom_range(int'(REG_BAND_HIGH) + 1, 255)), 10'($urandom_range(0, 1023)));
        write_reg(REG_BAND_HIGH, hi);
        band_phases++;
    endtask

    // Mostly real fades: a new goal followed by a run of ticks with junk in the
    // ignored percent field. The rest are single words of any kind.
    task automatic queue_fades(input int count);
        int left;
        int run;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_SET, 8'($urandom_range(0, 255)));
                else
                    send_word(OP_SET, 8'($urandom_range(0, int'(FULL_PCT))));
                left--;
                run = $urandom_range(1, 40);
                while (run > 0 && left > 0)
                begin
                    send_word(OP_TICK, 8'($urandom_range(0, 255)));
                    run--;
                    left--;
                end
            end
            else
            begin
                send_word($urandom_range(0, 1) ? OP_TICK : OP_SET, 8'($urandom_range(0, 255)));
                left--;
            end
        end
    endtask

    initial
    begin
        int lo;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words from the reset state: level 99 heading for 100.
        send_word(OP_TICK, 8'd0);     // Step to full brightness.
        send_word(OP_TICK, 8'd255);   // Already at the goal, nothing moves.
        send_word(OP_SET,  8'd255);   // Percent above 100 is clamped.
        send_word(OP_SET,  8'd101);
        send_word(OP_SET,  8'd100);
        send_word(OP_TICK, 8'd170);
        send_word(OP_SET,  8'd0);     // Start fading down.
        send_word(OP_TICK, 8'd85);
        send_word(OP_TICK, 8'd0);
        send_word(OP_TICK, 8'd255);
        send_word(OP_SET,  8'd97);    // Goal equals the current level.
        send_word(OP_TICK, 8'd1);
        send_word(OP_SET,  8'd128);
        send_word(OP_TICK, 8'd64);
        send_word(OP_SET,  8'd1);
        send_word(OP_TICK, 8'd127);
        wait_idle();

        // Full sweep down to zero and back up with the reset band, which walks
        // every level and passes through the band on both sides.
        send_word(OP_SET, 8'd0);
        repeat (101) send_word(OP_TICK, 8'($urandom_range(0, 255)));
        send_word(OP_SET, 8'd100);
        repeat (101) send_word(OP_TICK, 8'($urandom_range(0, 255)));

        // Band 519..535 has its midpoint at 527, a table value reached from
        // level 64 and 63, so the snap-high rule on the midpoint is hit.
        set_band(10'd519, 10'd535);
        send_word(OP_SET, 8'd63);
        repeat (40) send_word(OP_TICK, 8'($urandom_range(0, 255)));
        queue_fades(30);

        // Widest band: every nonzero duty below full scale snaps to an edge.
        set_band(10'd0, 10'd1023);
        queue_fades(45);

        // Inverted band: nothing can lie inside, so no snapping.
        set_band(10'd1023, 10'd0);
        queue_fades(45);

        // Band with no room inside, run without any idling.
        steady = 1'b1;
        set_band(10'd600, 10'd601);
        queue_fades(45);
        wait_idle();
        steady = 1'b0;

        set_band(10'd0, 10'd0);
        queue_fades(40);

        set_band(10'd1023, 10'd1023);
        queue_fades(40);

        repeat (2)
        begin
            lo = $urandom_range(300, 700);
            set_band(10'(lo), 10'(lo + $urandom_range(0, 150)));
            queue_fades(45);
        end

        set_band(BAND_LOW_RESET, BAND_HIGH_RESET);
        queue_fades(40);
        wait_idle();

        $display("Sent %0d words over %0d band settings with %0d register writes.",
                 words_sent, band_phases + 1, reg_writes);
        $display("Checked %0d result words, %0d of them with a new duty; %0d errors.",
                 reports_seen, duty_changes, errors);
        if (errors == 0)
            $display("backlight_fade_gamma_duty: match");
        else
            $display("backlight_fade_gamma_duty: mismatch");
        $finish;
    end

    // Watchdog: the slowest legal run is far shorter than this.
    initial
    begin
        #1000000;
        $display("Timed out with %0d result words still outstanding.", pending_reports.size());
        $display("backlight_fade_gamma_duty: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/bfgd_pkg.sv
rtl/bfgd_duty_map.sv
rtl/backlight_fade_gamma_duty.sv
bench/backlight_fade_gamma_duty_tb.sv
